@@ rtl/core/pts_pkg.sv @@
package pts_pkg;

	// Field widths of the stream payloads.
	localparam int ModeW    = 2;
	localparam int NowW     = 64;
	localparam int PeriodW  = 32;
	localparam int SlotW    = 4;
	localparam int KindW    = 3;
	localparam int InDataW  = 104;
	localparam int OutDataW = 8;

	// Request codes carried in the input tuser.
	localparam logic [ModeW-1:0] MODE_TICK   = 2'd0;
	localparam logic [ModeW-1:0] MODE_CREATE = 2'd1;
	localparam logic [ModeW-1:0] MODE_DELETE = 2'd2;

	// Result codes carried in the output tuser.
	localparam logic [KindW-1:0] KIND_CREATED  = 3'd0;
	localparam logic [KindW-1:0] KIND_DELETED  = 3'd1;
	localparam logic [KindW-1:0] KIND_FIRED    = 3'd2;
	localparam logic [KindW-1:0] KIND_DONE     = 3'd3;
	localparam logic [KindW-1:0] KIND_REJECTED = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Command from the sequencer to one slot cell.
	typedef struct packed {
		logic step;
		logic create;
		logic del;
	} cell_cmd_t;

	// Status from one slot cell back to the sequencer.
	typedef struct packed {
		logic allocated;
		logic del_pending;
		logic fire;
		logic release_id;
		logic tok;
	} cell_stat_t;

endpackage

@@ rtl/core/pts_cell.sv @@
module pts_cell import pts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_cmd_t          cmd,
	input  logic               tok_in,
	input  logic [NowW-1:0]    now,
	input  logic [PeriodW-1:0] period,
	output cell_stat_t         stat
);

	logic                tok_q;
	logic                alloc_q;
	logic                armed_q;
	logic                cp_q;
	logic                dp_q;
	logic [NowW-1:0]     deadline_q;
	logic [PeriodW-1:0]  interval_q;
	logic                due;
	logic                act;

	assign due = armed_q && (deadline_q <= now);
	assign act = cmd.step && tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			alloc_q <= 1'b0;
			armed_q <= 1'b0;
			cp_q    <= 1'b0;
			dp_q    <= 1'b0;
		end else begin
			if (cmd.step) begin
				tok_q <= tok_in;
			end
			if (cmd.create) begin
				alloc_q <= 1'b1;
				armed_q <= 1'b0;
				cp_q    <= 1'b1;
				dp_q    <= 1'b0;
			end else if (cmd.del) begin
				dp_q <= 1'b1;
			end else if (act) begin
				// A pending create is armed first; a pending delete then wins.
				if (cp_q) begin
					cp_q    <= 1'b0;
					armed_q <= 1'b1;
				end
				if (dp_q) begin
					dp_q    <= 1'b0;
					armed_q <= 1'b0;
					alloc_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create) begin
			interval_q <= period;
		end
		if (act) begin
			if (cp_q) begin
				deadline_q <= now + NowW'(interval_q);
			end else if (due) begin
				deadline_q <= deadline_q + NowW'(interval_q);
			end
		end
	end

	assign stat.allocated   = alloc_q;
	assign stat.del_pending = dp_q;
	assign stat.fire        = act && due;
	assign stat.release_id  = act && dp_q;
	assign stat.tok         = tok_q;

endmodule

@@ rtl/core/pts_free_fifo.sv @@
module pts_free_fifo import pts_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [$clog2(NUM_TIMERS)-1:0]     push_id,
	input  logic                              pop,
	output logic [$clog2(NUM_TIMERS)-1:0]     rd_id,
	output logic [$clog2(NUM_TIMERS+1)-1:0]   count
);

	localparam int IdW = $clog2(NUM_TIMERS);
	localparam int CntW = $clog2(NUM_TIMERS + 1);
	localparam logic [IdW-1:0] LastIdx = IdW'(NUM_TIMERS - 1);

	logic [IdW-1:0]  mem_q [NUM_TIMERS];
	logic [IdW-1:0]  head_q;
	logic [IdW-1:0]  tail_q;
	logic [CntW-1:0] count_q;
	logic [IdW-1:0]  rd_q;
	logic            push_ok;

	assign push_ok = push && (count_q < CntW'(NUM_TIMERS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				tail_q <= (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
			end
			if (push_ok && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[tail_q] <= push_id;
		end
		rd_q <= mem_q[head_q];
	end

	assign rd_id = rd_q;
	assign count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(NUM_TIMERS))
		else $error("free id queue holds more ids than there are slots");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("free id queue popped while empty");

endmodule

@@ rtl/core/periodic_timer_scheduler_unit.sv @@
// Channel  | Dir | Signals                        | Contents
// s_       | in  | tvalid tready tdata tuser      | request: mode, now, period, slot_id
// m_       | out | tvalid tready tdata tuser tlast| result: kind, slot_id_res, last
//
// A create or delete request is taken in the transfer, then decided in the ST_EXEC state.
// A tick is taken in the transfer; the scan token then walks the chain one slot cell per
// step in ST_SCAN, and ST_DONE gives the tick-done result.
// Every ST_EXEC, ST_SCAN and ST_DONE step is held while a result waits and m_tready is low.
// Reset (arst_n low) clears every slot, the free id queue and the id counter at once.
// A new request is taken while the last result still waits in the output register.
module periodic_timer_scheduler_unit import pts_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // now [63:0], period [95:64], slot_id [99:96]
	input  logic [ModeW-1:0]    s_tuser,   // mode [1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // slot_id_res [3:0]
	output logic [KindW-1:0]    m_tuser,   // kind [2:0]
	output logic                m_tlast
);

	localparam int IdW = $clog2(NUM_TIMERS);
	localparam int CntW = $clog2(NUM_TIMERS + 1);
	localparam logic [IdW-1:0] LastIdx = IdW'(NUM_TIMERS - 1);

	state_t               state_q;
	state_t               state_d;
	logic [ModeW-1:0]     mode_q;
	logic [NowW-1:0]      now_q;
	logic [PeriodW-1:0]   period_q;
	logic [SlotW-1:0]     sid_q;
	logic [IdW-1:0]       idx_q;
	logic [CntW-1:0]      nun_q;

	logic                 accept;
	logic                 launch;
	logic                 out_free;
	logic                 adv;
	logic                 exec_go;
	logic                 step;

	cell_cmd_t            cmd   [NUM_TIMERS];
	cell_stat_t           stat  [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] tok_vec;
	logic [NUM_TIMERS-1:0] fire_vec;
	logic [NUM_TIMERS-1:0] rel_vec;
	logic [NUM_TIMERS-1:0] alloc_vec;
	logic [NUM_TIMERS-1:0] dp_vec;

	logic [IdW-1:0]       fifo_rd;
	logic [CntW-1:0]      fifo_count;
	logic                 fifo_pop;

	logic                 create_ok;
	logic                 del_ok;
	logic [IdW-1:0]       new_id;
	logic [IdW-1:0]       sid_idx;
	logic                 do_create;
	logic                 do_delete;

	logic                 load;
	logic [KindW-1:0]     load_kind;
	logic [SlotW-1:0]     load_id;
	logic                 load_last;

	logic                 out_valid_q;
	logic [KindW-1:0]     out_kind_q;
	logic [SlotW-1:0]     out_id_q;
	logic                 out_last_q;

	// Input side: one request at a time, taken only by the idle sequencer.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign launch   = accept && (s_tuser == MODE_TICK);

	// The output register may be loaded when it is empty or being emptied.
	assign out_free = !out_valid_q || m_tready;
	assign adv      = (state_q == ST_SCAN) && out_free;
	assign exec_go  = (state_q == ST_EXEC) && out_free;
	assign step     = launch || adv;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= s_tuser;
			now_q    <= s_tdata[63:0];
			period_q <= s_tdata[95:64];
			sid_q    <= s_tdata[99:96];
		end
	end

	// Slot cells. The scan token enters cell 0 with the tick transfer and moves one
	// cell per step; the cell holding it handles firing, arming and removal.
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		logic tok_in;

		if (i == 0) begin : g_head
			assign tok_in = launch;
		end else begin : g_link
			assign tok_in = stat[i-1].tok;
		end

		assign cmd[i].step   = step;
		assign cmd[i].create = do_create && (new_id == IdW'(i));
		assign cmd[i].del    = do_delete && (sid_idx == IdW'(i));

		pts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[i]),
			.tok_in (tok_in),
			.now    (now_q),
			.period (period_q),
			.stat   (stat[i])
		);

		assign tok_vec[i]   = stat[i].tok;
		assign fire_vec[i]  = stat[i].fire;
		assign rel_vec[i]   = stat[i].release_id;
		assign alloc_vec[i] = stat[i].allocated;
		assign dp_vec[i]    = stat[i].del_pending;
	end

	// Released ids enter the queue in ascending order because the token walks
	// the chain from slot 0 upwards.
	pts_free_fifo #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_free_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (|rel_vec),
		.push_id (idx_q),
		.pop     (fifo_pop),
		.rd_id   (fifo_rd),
		.count   (fifo_count)
	);

	// Create: a recycled id first, then the next id never handed out. The queue's
	// registered read always shows the current head by the decision cycle.
	assign create_ok = (period_q != '0) &&
		((fifo_count != '0) || (nun_q < CntW'(NUM_TIMERS)));
	assign new_id    = (fifo_count != '0) ? fifo_rd : IdW'(nun_q);
	assign do_create = exec_go && (mode_q == MODE_CREATE) && create_ok;
	assign fifo_pop  = do_create && (fifo_count != '0);

	// Delete: the slot must exist, be allocated and not already be marked.
	assign sid_idx   = IdW'(sid_q);
	assign del_ok    = (32'(sid_q) < NUM_TIMERS) && alloc_vec[sid_idx] && !dp_vec[sid_idx];
	assign do_delete = exec_go && (mode_q == MODE_DELETE) && del_ok;

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		load_kind = KIND_REJECTED;
		load_id   = '0;
		load_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == MODE_TICK) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
					load    = 1'b1;
					unique case (mode_q)
						MODE_CREATE: begin
							if (create_ok) begin
								load_kind = KIND_CREATED;
								load_id   = SlotW'(new_id);
							end
						end
						MODE_DELETE: begin
							if (del_ok) begin
								load_kind = KIND_DELETED;
							end
						end
						default: begin
							load_kind = KIND_REJECTED;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (adv) begin
					if (|fire_vec) begin
						load      = 1'b1;
						load_kind = KIND_FIRED;
						load_id   = SlotW'(idx_q);
						load_last = 1'b0;
					end
					if (idx_q == LastIdx) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d   = ST_IDLE;
					load      = 1'b1;
					load_kind = KIND_DONE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			nun_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (launch) begin
				idx_q <= '0;
			end else if (adv) begin
				idx_q <= idx_q + 1'b1;
			end
			if (do_create && (fifo_count == '0)) begin
				nun_q <= nun_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= load_kind;
			out_id_q   <= load_id;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OutDataW'(out_id_q);
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_token_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one slot cell holds the scan token");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (tok_vec != '0))
		else $error("scan in progress but no cell holds the token");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("output register loaded over a result not yet transferred");

endmodule
